@@ rtl/gf256_arith_sbox_unit_core_assert.svh @@
// assertion macros used by the checker file
`ifndef GF256_ARITH_SBOX_UNIT_CORE_ASSERT_SVH
`define GF256_ARITH_SBOX_UNIT_CORE_ASSERT_SVH

// property checked at every clock edge outside reset
`define GFAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define GFAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/gfau_pkg.sv @@
// ----------------------------------------------------------------------------
// gfau_pkg
// Types, constants and GF(2^8) helper functions for the arithmetic/S-box unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

   localparam int unsigned ELEM_W    = 8;
   localparam int unsigned NUM_STEPS = 13;   // multiplies in the x^254 chain
   localparam logic [ELEM_W-1:0] AFFINE_CONST = 8'h63;
   localparam logic [ELEM_W-1:0] POLY_RESET   = 8'h1B;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_MUL  = 2'd1,
      OP_INV  = 2'd2,
      OP_SBOX = 2'd3
   } op_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [ELEM_W-1:0] a;
      logic [ELEM_W-1:0] b;
      logic [ELEM_W-1:0] x;
   } stage_type;

   // shift-and-add multiply, reducing by the configured polynomial
   function automatic logic [ELEM_W-1:0] gf_mul(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b,
                                                input logic [ELEM_W-1:0] poly);
      logic [ELEM_W-1:0] acc;
      logic [ELEM_W-1:0] aa;
      acc = '0;
      aa  = a;
      for (int i = 0; i < ELEM_W; i++) begin
         if (b[i]) begin
            acc = acc ^ aa;
         end
         aa = {aa[ELEM_W-2:0], 1'b0} ^ (aa[ELEM_W-1] ? poly : '0);
      end
      return acc;
   endfunction

   function automatic logic [ELEM_W-1:0] aes_affine(input logic [ELEM_W-1:0] v);
      logic [ELEM_W-1:0] res;
      for (int i = 0; i < ELEM_W; i++) begin
         res[i] = v[i] ^ v[(i + 4) % ELEM_W] ^ v[(i + 5) % ELEM_W] ^
                  v[(i + 6) % ELEM_W] ^ v[(i + 7) % ELEM_W] ^ AFFINE_CONST[i];
      end
      return res;
   endfunction

endpackage

@@ rtl/gfau_stage.sv @@
// ----------------------------------------------------------------------------
// gfau_stage
// One pipeline stage: a single GF(2^8) multiply (or, in the first stage, an add) followed by a register.
// ----------------------------------------------------------------------------
module gfau_stage #(
   parameter bit FIRST  = 1'b0,
   parameter bit SQUARE = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          poly,
   input  gfau_pkg::stage_type stage_in,
   output gfau_pkg::stage_type stage_out
);
   import gfau_pkg::*;

   logic              valid_ff;
   stage_type         data_ff;
   stage_type         data_in;
   logic [ELEM_W-1:0] mul_b;

   always_comb begin
      data_in       = stage_in;
      data_in.valid = 1'b0;
      mul_b         = SQUARE ? stage_in.x : stage_in.a;
      if (FIRST) begin
         case (stage_in.op)
            OP_ADD:  data_in.x = stage_in.a ^ stage_in.b;
            OP_MUL:  data_in.x = gf_mul(stage_in.a, stage_in.b, poly);
            default: data_in.x = gf_mul(stage_in.a, stage_in.a, poly);
         endcase
      end else if (stage_in.op == OP_INV || stage_in.op == OP_SBOX) begin
         data_in.x = gf_mul(stage_in.x, mul_b, poly);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end

endmodule

@@ rtl/gf256_arith_sbox_unit_core.sv @@
// ----------------------------------------------------------------------------
// gf256_arith_sbox_unit_core
// GF(2^8) add, multiply, inverse and AES S-box with a configurable polynomial.
// ----------------------------------------------------------------------------
// One transaction is taken in every clock cycle while busy is low, and
// each gives one result, strobed on rsp_valid in order. The latency is
// set by the inverse: x^254 is built as a chain of 13 dependent GF
// multiplies (square, multiply by x, alternately), one pipeline stage each,
// between an input register and an output register; add and multiply
// travel the same pipe. busy is high while reset is asserted and in the
// cycle after it is released. The polynomial register (byte address 0)
// must be written only while the pipe is empty.
module gf256_arith_sbox_unit_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_operand_a,
   input  logic [7:0]  req_operand_b,
   // result channel
   output logic        rsp_valid,
   output logic [7:0]  rsp_field_result,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import gfau_pkg::*;

   logic              busy_ff;
   logic [ELEM_W-1:0] poly_ff;
   logic              csr_wr;
   logic              valid_ff;
   stage_type         req_ff;
   stage_type         req_in;
   stage_type         chain [0:NUM_STEPS];
   stage_type         last;
   logic              rsp_valid_ff;
   logic [ELEM_W-1:0] result_ff;
   logic [ELEM_W-1:0] result_in;
   logic [ELEM_W-1:0] inv_val;

   // configuration
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
   assign prdata = (paddr[2] == 1'b0) ? {24'd0, poly_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr) begin
            poly_ff <= pwdata[ELEM_W-1:0];
         end
      end
   end

   assign busy = busy_ff;

   // input register
   always_comb begin
      req_in.valid = start && !busy_ff;
      req_in.op    = op_type'(req_type);
      req_in.a     = req_operand_a;
      req_in.b     = req_operand_b;
      req_in.x     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   always_comb begin
      chain[0]       = req_ff;
      chain[0].valid = valid_ff;
   end

   // exponent chain: x^2, x^3, x^6, x^7, ... x^127, x^254
   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      gfau_stage #(
         .FIRST  (k == 0),
         .SQUARE ((k % 2) == 0)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .poly      (poly_ff),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   assign last = chain[NUM_STEPS];

   // zero has no inverse and maps to zero
   always_comb begin
      inv_val = (last.a == '0) ? '0 : last.x;
      case (last.op)
         OP_INV:  result_in = inv_val;
         OP_SBOX: result_in = aes_affine(inv_val);
         default: result_in = last.x;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_result = result_ff;

endmodule

@@ rtl/gfau_checker.sv @@
// ----------------------------------------------------------------------------
// gfau_checker
// Port-level checks of latency, the add path and busy after reset of the core.
// ----------------------------------------------------------------------------
`include "gf256_arith_sbox_unit_core_assert.svh"

module gfau_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic [7:0] req_operand_a,
   input logic [7:0] req_operand_b,
   input logic       rsp_valid,
   input logic [7:0] rsp_field_result
);
   import gfau_pkg::*;

   logic accepted;
   logic add_req;

   assign accepted = start && !busy;
   assign add_req  = accepted && (req_type == OP_ADD);

   // every transaction gives its result after the fixed latency
   `GFAU_ASSERT(a_latency, clock, reset, accepted |-> ##15 rsp_valid, "result missing")

   // no result appears without a transaction behind it
   `GFAU_ASSERT(a_no_spurious, clock, reset, !accepted |-> ##15 !rsp_valid, "spurious result")

   // add path carries the xor of the operands
   `GFAU_ASSERT(a_add_value, clock, reset,
      add_req |-> ##15 (rsp_field_result == ($past(req_operand_a, 15) ^ $past(req_operand_b, 15))),
      "add result wrong")

   // reset leaves the unit refusing requests in the cycle after it
   `GFAU_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy, "busy low after reset")

endmodule

bind gf256_arith_sbox_unit_core gfau_checker u_gfau_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_type         (req_type),
   .req_operand_a    (req_operand_a),
   .req_operand_b    (req_operand_b),
   .rsp_valid        (rsp_valid),
   .rsp_field_result (rsp_field_result)
);
